/* rtl/core/bbum_pkg.sv */
// shared types, constants and register map for the box blur unsharp mask block
package bbum_pkg;

  localparam int CHAN_W = 8;
  localparam int CHANS  = 3;
  localparam int PIX_W  = CHANS * CHAN_W;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  // channel 0 is red, in the lowest bits
  typedef logic [CHANS-1:0][CHAN_W-1:0] pix_t;

  // input item kinds, carried on s_tuser
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_G_BITS = 4;

  // raster row counter, as wide as the image_height register
  localparam int ROW_W = 13;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int OFIFO_DEPTH   = 8;

  // floor(sum / 9) as (sum * 7282) >> 16, exact for sums up to 9 * 255
  localparam int SUM_W      = 12;
  localparam int RECIP_W    = 13;
  localparam int DIV9_SHIFT = 16;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SHARPEN_GAIN = 2'd2;

  localparam logic [CFG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] IMAGE_HEIGHT_RST = 13'd480;
  localparam logic [CFG_G_BITS-1:0] SHARPEN_GAIN_RST = 4'd2;

  typedef struct packed {
    logic [CFG_W_BITS-1:0] image_width;
    logic [CFG_H_BITS-1:0] image_height;
    logic [CFG_G_BITS-1:0] sharpen_gain;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } tag_t;

  typedef struct packed {
    logic frame_last;
    pix_t pix;
  } res_t;

endpackage

/* rtl/core/box_blur_unsharp_mask.sv */
// top level of the 3x3 box blur unsharp mask sharpener
//
// s_* takes rgb pixels in raster order, one per clock with s_tready high; tuser high
// marks a flush tick. m_* gives the sharpened pixels, tlast on a frame's final pixel.
// Registers (apb): image_width at 0x0, image_height at 0x4, sharpen_gain at 0x8;
// write them only while the block is idle.
// Stream lag: the result for a pixel leaves with the item width+1 positions
// later; after the last pixel of a frame send width+1 flush ticks to drain it.
// Pipeline: the item that releases a result passes the line ram read, window
// shift, box sum, divide by nine and sharpen before the result is presented.
// Throughput: one item per clock while s_tready is high; the line buffer ram
// has one read and one write port, each used at most once per item.
// Reset: counters clear, registers return to 640 x 480 with gain 2, and a
// clearing sweep zeroes every line buffer entry, with s_tready low throughout.
// Stall: results queue in an 8-entry buffer; outside the clearing sweep, s_tready
// drops only when the queue plus the items still in the pipeline would fill it.
module box_blur_unsharp_mask #(
  parameter int MAX_WIDTH = bbum_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,  // red_in, green_in, blue_in
  input  logic                        s_tuser,  // opcode
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,  // red_out, green_out, blue_out
  output logic                        m_tlast,  // frame_last
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bbum_pkg::APB_AW-1:0] paddr,
  input  logic [bbum_pkg::APB_DW-1:0] pwdata,
  output logic [bbum_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(bbum_pkg::OFIFO_DEPTH + 1);
  localparam int OW = NW + 1;

  bbum_pkg::cfg_t cfg;
  logic           accept;
  logic           rd_en;
  logic [CW-1:0]  rd_addr;
  logic           s1_valid;
  logic [CW-1:0]  s1_addr;
  bbum_pkg::pix_t s1_pix;
  bbum_pkg::tag_t s1_tag;
  bbum_pkg::pix_t row_top;
  bbum_pkg::pix_t row_mid;
  logic           clear_busy;
  logic           res_valid;
  bbum_pkg::res_t res;
  bbum_pkg::res_t out_res;
  logic [1:0]     pend;
  logic [NW-1:0]  fifo_count;
  logic [OW-1:0]  occupancy;

  assign occupancy = OW'(fifo_count) + OW'(pend) + OW'(s1_valid && s1_tag.emit);
  assign s_tready  = !clear_busy && (occupancy < OW'(bbum_pkg::OFIFO_DEPTH));
  assign accept    = s_tvalid && s_tready;

  bbum_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  bbum_raster #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_raster (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .opcode  (s_tuser),
    .pix     (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .s1_valid(s1_valid),
    .s1_addr (s1_addr),
    .s1_pix  (s1_pix),
    .s1_tag  (s1_tag)
  );

  bbum_linebuf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_linebuf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1_addr   (s1_addr),
    .s1_pix    (s1_pix),
    .row_top   (row_top),
    .row_mid   (row_mid),
    .clear_busy(clear_busy)
  );

  bbum_filter u_filter (
    .clk      (clk),
    .rst      (rst),
    .gain     (cfg.sharpen_gain),
    .s1_valid (s1_valid),
    .s1_tag   (s1_tag),
    .s1_pix   (s1_pix),
    .row_top  (row_top),
    .row_mid  (row_mid),
    .res_valid(res_valid),
    .res      (res),
    .pend     (pend)
  );

  bbum_ofifo #(
    .DEPTH(bbum_pkg::OFIFO_DEPTH)
  ) u_ofifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_ready(m_tready),
    .rd_valid(m_tvalid),
    .rd_data (out_res),
    .count   (fifo_count)
  );

  assign m_tdata = out_res.pix;
  assign m_tlast = out_res.frame_last;

  // results queued or in flight never exceed the output buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OW'(bbum_pkg::OFIFO_DEPTH))
    else $error("result occupancy exceeds output buffer");

  // nothing is in flight while the line buffer is being cleared
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> (occupancy == '0) && !m_tvalid && !s1_valid)
    else $error("activity during line buffer clearing");

  // a result enters the queue only from an item that was transferred earlier
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(s1_valid, 3) && !clear_busy)
    else $error("result without a source item");

endmodule

/* rtl/core/bbum_ram.sv */
// generic single write port ram with registered read
module bbum_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/bbum_regs.sv */
// apb configuration registers: width, height, gain
module bbum_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bbum_pkg::APB_AW-1:0] paddr,
  input  logic [bbum_pkg::APB_DW-1:0] pwdata,
  output logic [bbum_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output bbum_pkg::cfg_t             cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= bbum_pkg::IMAGE_WIDTH_RST;
      cfg.image_height <= bbum_pkg::IMAGE_HEIGHT_RST;
      cfg.sharpen_gain <= bbum_pkg::SHARPEN_GAIN_RST;
    end else if (wr) begin
      if (idx == bbum_pkg::REG_IMAGE_WIDTH) begin
        cfg.image_width <= pwdata[bbum_pkg::CFG_W_BITS-1:0];
      end
      if (idx == bbum_pkg::REG_IMAGE_HEIGHT) begin
        cfg.image_height <= pwdata[bbum_pkg::CFG_H_BITS-1:0];
      end
      if (idx == bbum_pkg::REG_SHARPEN_GAIN) begin
        cfg.sharpen_gain <= pwdata[bbum_pkg::CFG_G_BITS-1:0];
      end
    end
  end

  always_comb begin
    unique case (idx)
      bbum_pkg::REG_IMAGE_WIDTH:  prdata = bbum_pkg::APB_DW'(cfg.image_width);
      bbum_pkg::REG_IMAGE_HEIGHT: prdata = bbum_pkg::APB_DW'(cfg.image_height);
      bbum_pkg::REG_SHARPEN_GAIN: prdata = bbum_pkg::APB_DW'(cfg.sharpen_gain);
      default:                    prdata = '0;
    endcase
  end

endmodule

/* rtl/core/bbum_raster.sv */
// raster position counters, drain handling and per-item output tags
module bbum_raster #(
  parameter int MAX_WIDTH = bbum_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bbum_pkg::cfg_t               cfg,
  input  logic                         accept,
  input  logic                         opcode,
  input  bbum_pkg::pix_t               pix,
  output logic                         rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic                         s1_valid,
  output logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  output bbum_pkg::pix_t               s1_pix,
  output bbum_pkg::tag_t               s1_tag
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int EW = (WW > bbum_pkg::CFG_W_BITS) ? WW : bbum_pkg::CFG_W_BITS;
  localparam int RW = bbum_pkg::ROW_W;

  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic [EW-1:0] w_ext;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] w_m1;
  logic [RW-1:0] h_eff;
  logic          draining;
  logic          take;
  logic          emit;
  logic          interior;
  logic          last;
  logic [CW-1:0] ocol;
  logic [RW-1:0] orow;
  logic [WW-1:0] col_inc;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  always_comb begin
    w_ext = EW'(cfg.image_width);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext[WW-1:0];
    end
    w_m1  = w_eff - WW'(1);
    h_eff = (cfg.image_height == '0) ? RW'(1) : RW'(cfg.image_height);

    draining = row >= h_eff;
    // an early flush tick does nothing
    take = accept && !((opcode == bbum_pkg::OP_FLUSH) && !draining);

    emit = (row >= RW'(2)) || (row == RW'(1) && col != '0);
    if (col == '0) begin
      ocol = w_m1[CW-1:0];
      orow = (row >= RW'(2)) ? row - RW'(2) : '0;
    end else begin
      ocol = col - CW'(1);
      orow = (row >= RW'(1)) ? row - RW'(1) : '0;
    end

    interior = (ocol != '0) && (WW'(ocol) + WW'(2) <= w_eff) &&
               (orow != '0) && (orow + RW'(2) <= h_eff);
    last     = (orow + RW'(1) >= h_eff) && (WW'(ocol) + WW'(1) >= w_eff);

    col_inc = WW'(col) + WW'(1);
    if (emit && last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = row + RW'(1);
    end else begin
      col_next = col_inc[CW-1:0];
      row_next = row;
    end
  end

  assign rd_en   = take;
  assign rd_addr = col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
      if (take) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr       <= col;
      // a pixel that arrives while draining is dropped
      s1_pix        <= draining ? '0 : pix;
      s1_tag.emit     <= emit;
      s1_tag.interior <= interior;
      s1_tag.last     <= last;
    end
  end

endmodule

/* rtl/core/bbum_linebuf.sv */
// two-row line buffer in one ram word, with clearing sweep and write forwarding
module bbum_linebuf #(
  parameter int MAX_WIDTH = bbum_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         s1_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0] s1_addr,
  input  bbum_pkg::pix_t               s1_pix,
  output bbum_pkg::pix_t               row_top,
  output bbum_pkg::pix_t               row_mid,
  output logic                         clear_busy
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = 2 * bbum_pkg::PIX_W;

  logic [CW-1:0] clr_addr;
  logic          fwd;
  logic [LW-1:0] fwd_data;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] rows;
  logic [LW-1:0] wdata_s1;
  logic          we;
  logic [CW-1:0] waddr;
  logic [LW-1:0] wdata;

  // lower half is the row just above the input, upper half the one above that
  assign rows     = fwd ? fwd_data : ram_rdata;
  assign row_mid  = rows[bbum_pkg::PIX_W-1:0];
  assign row_top  = rows[LW-1:bbum_pkg::PIX_W];
  assign wdata_s1 = {rows[bbum_pkg::PIX_W-1:0], s1_pix};

  assign we    = clear_busy | s1_valid;
  assign waddr = clear_busy ? clr_addr : s1_addr;
  assign wdata = clear_busy ? '0 : wdata_s1;

  bbum_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
      fwd        <= 1'b0;
    end else begin
      if (clear_busy) begin
        clr_addr <= clr_addr + CW'(1);
        if (clr_addr == CW'(MAX_WIDTH - 1)) begin
          clear_busy <= 1'b0;
        end
      end
      // read hits the entry being written in the same cycle
      fwd <= rd_en && s1_valid && (s1_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata_s1;
  end

endmodule

/* rtl/core/bbum_filter.sv */
// 3x3 window, box sum and divide by nine, one stage each; sharpen combinational
module bbum_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [bbum_pkg::CFG_G_BITS-1:0]     gain,
  input  logic                                s1_valid,
  input  bbum_pkg::tag_t                      s1_tag,
  input  bbum_pkg::pix_t                      s1_pix,
  input  bbum_pkg::pix_t                      row_top,
  input  bbum_pkg::pix_t                      row_mid,
  output logic                                res_valid,
  output bbum_pkg::res_t                      res,
  output logic [1:0]                          pend
);

  localparam int CH  = bbum_pkg::CHANS;
  localparam int CHW = bbum_pkg::CHAN_W;
  localparam int SW  = bbum_pkg::SUM_W;
  localparam int PW  = bbum_pkg::SUM_W + bbum_pkg::RECIP_W;
  localparam int MW  = bbum_pkg::CHAN_W + bbum_pkg::CFG_G_BITS;

  bbum_pkg::pix_t [2:0][2:0] win;

  logic            w_valid;
  bbum_pkg::tag_t  w_tag;
  logic [CH-1:0][SW-1:0] sum;

  logic            s2_valid;
  logic [CH-1:0][SW-1:0] s2_sum;
  bbum_pkg::pix_t  s2_ctr;
  logic            s2_interior;
  logic            s2_last;
  logic [CH-1:0][PW-1:0] prod;

  logic            s3_valid;
  logic [CH-1:0][CHW-1:0] s3_blur;
  bbum_pkg::pix_t  s3_ctr;
  logic            s3_last;

  logic [CH-1:0][CHW-1:0] detail;
  logic [CH-1:0][MW-1:0]  boost;
  logic [CH-1:0][MW:0]    sharp;

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      w_valid  <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i][0] <= win[i][1];
          win[i][1] <= win[i][2];
        end
        win[0][2] <= row_top;
        win[1][2] <= row_mid;
        win[2][2] <= s1_pix;
      end
      w_valid  <= s1_valid && s1_tag.emit;
      s2_valid <= w_valid;
      s3_valid <= s2_valid;
    end
  end

  always_comb begin
    for (int k = 0; k < CH; k++) begin
      sum[k] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sum[k] = sum[k] + SW'(win[i][j][k]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CH; k++) begin
      prod[k] = PW'(s2_sum[k]) * PW'(bbum_pkg::DIV9_RECIP);
    end
  end

  always_comb begin
    for (int k = 0; k < CH; k++) begin
      detail[k] = (s3_ctr[k] > s3_blur[k]) ? s3_ctr[k] - s3_blur[k] : '0;
      boost[k]  = MW'(detail[k]) * MW'(gain);
      sharp[k]  = (MW + 1)'(boost[k]) + (MW + 1)'(s3_ctr[k]);
      res.pix[k] = (sharp[k] > (MW + 1)'(bbum_pkg::CHAN_MAX)) ?
                   bbum_pkg::CHAN_MAX : sharp[k][CHW-1:0];
    end
    res.frame_last = s3_last;
  end

  always_ff @(posedge clk) begin
    w_tag       <= s1_tag;
    s2_sum      <= sum;
    s2_ctr      <= win[1][1];
    s2_interior <= w_tag.interior;
    s2_last     <= w_tag.last;
    for (int k = 0; k < CH; k++) begin
      // border pixels use a blur of zero
      s3_blur[k] <= s2_interior ? prod[k][bbum_pkg::DIV9_SHIFT +: CHW] : '0;
    end
    s3_ctr  <= s2_ctr;
    s3_last <= s2_last;
  end

  assign res_valid = s3_valid;
  assign pend      = 2'(w_valid) + 2'(s2_valid) + 2'(s3_valid);

endmodule

/* rtl/core/bbum_ofifo.sv */
// result queue that decouples the filter pipeline from the output stall
module bbum_ofifo #(
  parameter int DEPTH = bbum_pkg::OFIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  bbum_pkg::res_t             wr_data,
  input  logic                       rd_ready,
  output logic                       rd_valid,
  output bbum_pkg::res_t             rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  bbum_pkg::res_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic           rd_en;

  assign rd_valid = count != '0;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + NW'(wr_en) - NW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* bench/tb_box_blur_unsharp_mask.sv */
// self-checking bench for the unsharp mask sharpener: directed frames, then random frames
`timescale 1ns / 100ps

module tb_box_blur_unsharp_mask;

  localparam int LINE_DEPTH   = bbum_pkg::MAX_WIDTH_DEF;
  localparam int WIDE_ROW     = 64;
  localparam int TALL_COL     = 96;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 3_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;  // red_in, green_in, blue_in
  logic s_tuser = 1'b0;       // opcode
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;       // red_out, green_out, blue_out
  logic m_tlast;              // frame_last
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bbum_pkg::APB_AW-1:0] paddr = '0;
  logic [bbum_pkg::APB_DW-1:0] pwdata = '0;
  logic [bbum_pkg::APB_DW-1:0] prdata;
  logic pready;

  box_blur_unsharp_mask #(.MAX_WIDTH(LINE_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sharpener state as the bench sees it
  logic [bbum_pkg::CFG_W_BITS-1:0] reg_width;
  logic [bbum_pkg::CFG_H_BITS-1:0] reg_height;
  logic [bbum_pkg::CFG_G_BITS-1:0] reg_gain;
  bbum_pkg::pix_t line_new [LINE_DEPTH];  // row just above the input
  bbum_pkg::pix_t line_old [LINE_DEPTH];  // two rows above the input
  bbum_pkg::pix_t win [3][3];
  int unsigned row_pos, col_pos;

  bbum_pkg::res_t expected_pixels [$];
  int unsigned mismatches = 0;
  int unsigned items_done = 0;
  int unsigned taken_count = 0;
  int unsigned stall_seen = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > LINE_DEPTH) return LINE_DEPTH;
    return reg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_new[i] = '0;
      line_old[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    row_pos = 0;
    col_pos = 0;
    reg_width = bbum_pkg::IMAGE_WIDTH_RST;
    reg_height = bbum_pkg::IMAGE_HEIGHT_RST;
    reg_gain = bbum_pkg::SHARPEN_GAIN_RST;
  endfunction

  function automatic logic [bbum_pkg::CHAN_W-1:0] sharpen_chan(input int k, input bit interior);
    int unsigned v, sum, blur, detail, boosted;
    v = win[1][1][k];
    sum = 0;
    blur = 0;
    if (interior) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) sum += win[i][j][k];
      end
      blur = sum / 9;
    end
    detail = (v > blur) ? v - blur : 0;
    boosted = v + reg_gain * detail;
    return (boosted > bbum_pkg::CHAN_MAX) ? bbum_pkg::CHAN_MAX : bbum_pkg::CHAN_W'(boosted);
  endfunction

  // advances the state by one item; returns 1 when a sharpened pixel leaves
  function automatic bit sharpen_step(input logic op, input bbum_pkg::pix_t px_in,
                                      output bbum_pkg::res_t res);
    int unsigned w, h, r, c, idx, orow, ocol;
    bit draining, emit, interior;
    bbum_pkg::pix_t px;
    w = eff_width();
    h = eff_height();
    r = row_pos;
    c = col_pos;
    res = '0;
    draining = (r >= h);
    if (op == bbum_pkg::OP_FLUSH && !draining) return 1'b0;
    // once the frame is in, pixel items only drain and their data is dropped
    px = draining ? '0 : px_in;
    idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_old[idx];
    win[1][2] = line_new[idx];
    win[2][2] = px;
    line_old[idx] = line_new[idx];
    line_new[idx] = px;
    emit = (r >= 2) || (r == 1 && c >= 1);
    if (c == 0) begin
      ocol = w - 1;
      orow = (r >= 2) ? r - 2 : 0;
    end else begin
      ocol = c - 1;
      orow = (r >= 1) ? r - 1 : 0;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    row_pos = r;
    col_pos = c;
    if (!emit) return 1'b0;
    interior = ocol >= 1 && ocol + 2 <= w && orow >= 1 && orow + 2 <= h;
    res.frame_last = (orow + 1 >= h) && (ocol + 1 >= w);
    for (int k = 0; k < bbum_pkg::CHANS; k++) res.pix[k] = sharpen_chan(k, interior);
    if (res.frame_last) begin
      row_pos = 0;
      col_pos = 0;
    end
    return 1'b1;
  endfunction

  function automatic bbum_pkg::pix_t rgb(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    return {b, g, r};
  endfunction

  function automatic bbum_pkg::pix_t rand_pix();
    bbum_pkg::pix_t p;
    for (int k = 0; k < bbum_pkg::CHANS; k++) begin
      case ($urandom_range(0, 5))
        0: p[k] = '0;
        1: p[k] = bbum_pkg::CHAN_MAX;
        default: p[k] = bbum_pkg::CHAN_W'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_box_blur_unsharp_mask NOT OK");
      $finish;
    end
  end

  // output checker
  always @(posedge clk) begin
    bbum_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      taken_count++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected output transfer: tdata %h tlast %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata[7:0] !== want.pix[0]) begin
          $error("red_out: expected %0d, actual %0d", want.pix[0], m_tdata[7:0]);
          mismatches++;
        end
        if (m_tdata[15:8] !== want.pix[1]) begin
          $error("green_out: expected %0d, actual %0d", want.pix[1], m_tdata[15:8]);
          mismatches++;
        end
        if (m_tdata[23:16] !== want.pix[2]) begin
          $error("blue_out: expected %0d, actual %0d", want.pix[2], m_tdata[23:16]);
          mismatches++;
        end
        if (m_tlast !== want.frame_last) begin
          $error("frame_last: expected %0d, actual %0d", want.frame_last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // receiver stalls, drawn after each output transfer
  always @(negedge clk) begin
    if (taken_count != stall_seen) begin
      stall_seen = taken_count;
      stall_left = recv_burst ? 0 : $urandom_range(0, 11);
    end
    if ($urandom_range(0, 299) == 0) recv_burst = !recv_burst;
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input bbum_pkg::pix_t px);
    int unsigned gap;
    bbum_pkg::res_t res;
    bit ignored;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    ignored = (op == bbum_pkg::OP_FLUSH) && (row_pos < eff_height());
    if (sharpen_step(op, px, res)) expected_pixels.push_back(res);
    if (!ignored) items_done++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic read_reg(input logic [1:0] idx);
    logic [bbum_pkg::APB_DW-1:0] want;
    case (idx)
      bbum_pkg::REG_IMAGE_WIDTH:  want = bbum_pkg::APB_DW'(reg_width);
      bbum_pkg::REG_IMAGE_HEIGHT: want = bbum_pkg::APB_DW'(reg_height);
      default:                    want = bbum_pkg::APB_DW'(reg_gain);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("register %0d: expected %0d, actual %0d", idx, want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [bbum_pkg::APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      bbum_pkg::REG_IMAGE_WIDTH:  reg_width = value[bbum_pkg::CFG_W_BITS-1:0];
      bbum_pkg::REG_IMAGE_HEIGHT: reg_height = value[bbum_pkg::CFG_H_BITS-1:0];
      default:                    reg_gain = value[bbum_pkg::CFG_G_BITS-1:0];
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    read_reg(idx);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned g);
    write_reg(bbum_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bbum_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(bbum_pkg::REG_SHARPEN_GAIN, g);
  endtask

  task automatic send_pixels(input int unsigned count, input bit noisy);
    repeat (count) begin
      // a flush tick while pixels are still due must be dropped
      if (noisy && $urandom_range(0, 24) == 0) send_item(bbum_pkg::OP_FLUSH, rand_pix());
      send_item(bbum_pkg::OP_PIXEL, rand_pix());
    end
  endtask

  // sends items until the next one starts a frame
  task automatic finish_frame();
    while (row_pos != 0 || col_pos != 0) begin
      if (row_pos < eff_height() || $urandom_range(0, 6) == 0)
        send_item(bbum_pkg::OP_PIXEL, rand_pix());
      else
        send_item(bbum_pkg::OP_FLUSH, rand_pix());
    end
  endtask

  task automatic test_register_reset();
    read_reg(bbum_pkg::REG_IMAGE_WIDTH);
    read_reg(bbum_pkg::REG_IMAGE_HEIGHT);
    read_reg(bbum_pkg::REG_SHARPEN_GAIN);
  endtask

  task automatic test_saturation_window();
    bbum_pkg::pix_t grid [9];
    grid[0] = rgb(8'd0, 8'd255, 8'd0);
    grid[1] = rgb(8'd255, 8'd255, 8'd0);
    grid[2] = rgb(8'd0, 8'd255, 8'd1);
    grid[3] = rgb(8'd0, 8'd254, 8'd255);
    grid[4] = rgb(8'd255, 8'd1, 8'd100);
    grid[5] = rgb(8'd0, 8'd255, 8'd0);
    grid[6] = rgb(8'd1, 8'd255, 8'd255);
    grid[7] = rgb(8'd255, 8'd128, 8'd0);
    grid[8] = rgb(8'd0, 8'd255, 8'd255);
    set_frame(3, 3, 15);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_item(bbum_pkg::OP_FLUSH, rgb(8'd255, 8'd255, 8'd255));
      send_item(bbum_pkg::OP_PIXEL, grid[i]);
    end
    send_item(bbum_pkg::OP_FLUSH, '0);
    send_item(bbum_pkg::OP_PIXEL, rgb(8'd255, 8'd255, 8'd255));
    finish_frame();
    wait_idle();
  endtask

  // zero sizes count as one pixel
  task automatic test_degenerate_sizes();
    set_frame(0, 0, 0);
    send_item(bbum_pkg::OP_FLUSH, '0);
    send_item(bbum_pkg::OP_PIXEL, rgb(8'd255, 8'd0, 8'd255));
    send_item(bbum_pkg::OP_PIXEL, rgb(8'd0, 8'd255, 8'd0));
    send_item(bbum_pkg::OP_FLUSH, '0);
    wait_idle();
  endtask

  task automatic test_mid_frame_change();
    set_frame(4, 4, 3);
    send_pixels(6, 1'b0);
    wait_idle();
    write_reg(bbum_pkg::REG_IMAGE_WIDTH, 3);
    send_pixels(3, 1'b0);
    wait_idle();
    write_reg(bbum_pkg::REG_IMAGE_HEIGHT, 2);
    finish_frame();
    wait_idle();
  endtask

  // wide rows at full rate, and a width register past the line buffer
  task automatic test_widest_rows();
    send_burst = 1'b1;
    set_frame(WIDE_ROW, 3, $urandom_range(0, 15));
    send_pixels(3 * WIDE_ROW, 1'b0);
    finish_frame();
    wait_idle();
    send_burst = 1'b0;
    set_frame(2047, 2, $urandom_range(0, 15));
    send_pixels(6, 1'b0);
    wait_idle();
    write_reg(bbum_pkg::REG_IMAGE_WIDTH, 4);
    finish_frame();
    wait_idle();
  endtask

  task automatic test_tallest_column();
    set_frame(1, TALL_COL, 15);
    send_pixels(TALL_COL, 1'b0);
    finish_frame();
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start, nframes, w, h, g;
    start = items_done;
    while (items_done - start < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = 1;
        2: w = $urandom_range(12, 24);
        default: w = $urandom_range(2, 9);
      endcase
      case ($urandom_range(0, 7))
        0: h = 0;
        1: h = 1;
        default: h = $urandom_range(2, 6);
      endcase
      case ($urandom_range(0, 3))
        0: g = 0;
        1: g = 15;
        default: g = $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(bbum_pkg::REG_IMAGE_WIDTH, w);
      if ($urandom_range(0, 3) != 0) write_reg(bbum_pkg::REG_IMAGE_HEIGHT, h);
      if ($urandom_range(0, 3) != 0) write_reg(bbum_pkg::REG_SHARPEN_GAIN, g);
      send_burst = ($urandom_range(0, 3) == 0);
      nframes = $urandom_range(1, 3);
      repeat (nframes) begin
        send_pixels(eff_width() * eff_height(), 1'b1);
        for (int i = 0; i <= eff_width(); i++) begin
          // a cut-short drain lets the next frame's pixels finish this one
          if ($urandom_range(0, 29) == 0) break;
          if ($urandom_range(0, 6) == 0) send_item(bbum_pkg::OP_PIXEL, rand_pix());
          else send_item(bbum_pkg::OP_FLUSH, rand_pix());
        end
      end
      finish_frame();
    end
    send_burst = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_register_reset();
    test_saturation_window();
    test_degenerate_sizes();
    test_mid_frame_change();
    test_widest_rows();
    test_tallest_column();
    test_random_frames();
    wait_idle();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("tb_box_blur_unsharp_mask OK");
    end else begin
      $display("tb_box_blur_unsharp_mask NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/bbum_pkg.sv
rtl/core/bbum_ram.sv
rtl/core/bbum_regs.sv
rtl/core/bbum_raster.sv
rtl/core/bbum_linebuf.sv
rtl/core/bbum_filter.sv
rtl/core/bbum_ofifo.sv
rtl/core/box_blur_unsharp_mask.sv
bench/tb_box_blur_unsharp_mask.sv
